// ----- rtl/delhd_pkg.sv -----
// ============================================================================
// delhd_pkg: shared types and constants
// Field types, configuration register indexes and flag bit positions for the
// debounced edge and long-hold detector.
// ============================================================================
package delhd_pkg;

    localparam int CHANNELS = 8;

    typedef logic [2:0]  chan_t;
    typedef logic [31:0] tick_t;
    typedef logic [4:0]  flags_t;
    typedef logic [7:0]  hist_t;
    typedef logic [7:0]  chan_mask_t;
    typedef logic [1:0]  cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_LONG_HOLD_TIME = 2'd0;
    localparam cfg_idx_t CFG_CHANNEL_ENABLE = 2'd1;

    localparam tick_t      LONG_HOLD_RESET = 32'd1000;
    localparam chan_mask_t ENABLE_RESET    = 8'hFF;

    // Flag bit positions within flags_t
    localparam int FLAG_HIGH      = 0;
    localparam int FLAG_LONG_HIGH = 1;
    localparam int FLAG_LONG_LOW  = 2;
    localparam int FLAG_RISING    = 3;
    localparam int FLAG_FALLING   = 4;

    // Sample history patterns
    localparam hist_t HIST_ALL_HIGH = 8'hFF;
    localparam hist_t HIST_ALL_LOW  = 8'h00;
    localparam hist_t HIST_RISE     = 8'h0F;
    localparam hist_t HIST_FALL     = 8'hF0;

endpackage

// ----- rtl/debounce_edge_long_hold_detector.sv -----
// ============================================================================
// debounce_edge_long_hold_detector
// Per-channel shift-register debouncer with sticky edge and long-hold flags.
// ============================================================================
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  channel, level, now_time, clear_flags
//  result   out        out_valid/ out_stall out_channel, is_high, long_high,
//                                           long_low, rising_seen, falling_seen
//  config   in         cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One sample is accepted per cycle unless the input is stalled. The accepting
// edge loads the input register; the result register is loaded from it when it
// is empty or its result is not stalled, and offers the result to the output.
// The channel state is updated at the edge that loads the result register,
// so a following sample of the same channel sees it without forwarding.
// Reset clears all channel state and restores the configuration defaults.
// A stalled result holds the pipeline; input stall rises only then.
module debounce_edge_long_hold_detector
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  delhd_pkg::chan_t    channel,
    input  logic                level,
    input  delhd_pkg::tick_t    now_time,
    input  delhd_pkg::flags_t   clear_flags,

    output logic                out_valid,
    input  logic                out_stall,
    output delhd_pkg::chan_t    out_channel,
    output logic                is_high,
    output logic                long_high,
    output logic                long_low,
    output logic                rising_seen,
    output logic                falling_seen,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  delhd_pkg::cfg_idx_t cfg_index,
    input  delhd_pkg::tick_t    cfg_data
);
    import delhd_pkg::*;

    // Configuration
    tick_t      long_hold_reg;
    chan_mask_t enable_reg;

    // Input register
    logic   s1_valid_reg;
    chan_t  s1_chan_reg;
    logic   s1_level_reg;
    tick_t  s1_now_reg;
    flags_t s1_clear_reg;

    // Result register
    logic   res_valid_reg;
    chan_t  res_chan_reg;
    flags_t res_flags_reg;
    flags_t res_flags_next;

    // Channel state
    hist_t  hist_reg  [CHANNELS];
    tick_t  rise_reg  [CHANNELS];
    tick_t  fall_reg  [CHANNELS];
    flags_t flags_reg [CHANNELS];

    hist_t  hist_next;
    tick_t  rise_next;
    tick_t  fall_next;
    flags_t flags_next;

    logic   advance;
    logic   in_range;
    logic   enabled;
    logic   do_update;
    tick_t  rise_limit;
    tick_t  fall_limit;

    assign cfg_ready = 1'b1;
    assign advance   = !res_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg <= LONG_HOLD_RESET;
            enable_reg    <= ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LONG_HOLD_TIME: long_hold_reg <= cfg_data;
                CFG_CHANNEL_ENABLE: enable_reg    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_chan_reg  <= channel;
            s1_level_reg <= level;
            s1_now_reg   <= now_time;
            s1_clear_reg <= clear_flags;
        end
    end

    assign in_range   = 32'(s1_chan_reg) < CHANNELS;
    assign enabled    = enable_reg[s1_chan_reg];
    assign do_update  = s1_valid_reg && advance && in_range && enabled;
    assign rise_limit = rise_reg[s1_chan_reg] + long_hold_reg;
    assign fall_limit = fall_reg[s1_chan_reg] + long_hold_reg;

    always_comb
    begin
        hist_next  = {hist_reg[s1_chan_reg][6:0], s1_level_reg};
        rise_next  = rise_reg[s1_chan_reg];
        fall_next  = fall_reg[s1_chan_reg];
        flags_next = flags_reg[s1_chan_reg] & ~s1_clear_reg;

        case (hist_next)
            HIST_ALL_HIGH:
            begin
                flags_next[FLAG_HIGH] = 1'b1;
                if (s1_now_reg >= rise_limit)
                begin
                    flags_next[FLAG_LONG_HIGH] = 1'b1;
                    rise_next                  = '0;
                end
            end
            HIST_ALL_LOW:
            begin
                flags_next[FLAG_HIGH] = 1'b0;
                if (s1_now_reg >= fall_limit)
                begin
                    flags_next[FLAG_LONG_LOW] = 1'b1;
                    fall_next                 = '0;
                end
            end
            HIST_RISE:
            begin
                flags_next[FLAG_RISING] = 1'b1;
                rise_next               = s1_now_reg;
            end
            HIST_FALL:
            begin
                flags_next[FLAG_FALLING] = 1'b1;
                fall_next                = s1_now_reg;
            end
            default: ;
        endcase

        // Disabled channels report their stored flags; absent ones report none.
        if (!in_range)
            res_flags_next = '0;
        else if (!enabled)
            res_flags_next = flags_reg[s1_chan_reg];
        else
            res_flags_next = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                hist_reg[i]  <= '0;
                rise_reg[i]  <= '0;
                fall_reg[i]  <= '0;
                flags_reg[i] <= '0;
            end
        end
        else if (do_update)
        begin
            hist_reg[s1_chan_reg]  <= hist_next;
            rise_reg[s1_chan_reg]  <= rise_next;
            fall_reg[s1_chan_reg]  <= fall_next;
            flags_reg[s1_chan_reg] <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_chan_reg  <= s1_chan_reg;
            res_flags_reg <= res_flags_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign out_channel  = res_chan_reg;
    assign is_high      = res_flags_reg[FLAG_HIGH];
    assign long_high    = res_flags_reg[FLAG_LONG_HIGH];
    assign long_low     = res_flags_reg[FLAG_LONG_LOW];
    assign rising_seen  = res_flags_reg[FLAG_RISING];
    assign falling_seen = res_flags_reg[FLAG_FALLING];

endmodule

// ----- rtl/delhd_checker.sv -----
// ============================================================================
// delhd_checker: port-level checks
// Watches the detector's ports for stall, reset and result behaviour.
// ============================================================================
module delhd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input delhd_pkg::chan_t    channel,
    input logic                level,
    input delhd_pkg::tick_t    now_time,
    input delhd_pkg::flags_t   clear_flags,
    input logic                out_valid,
    input logic                out_stall,
    input delhd_pkg::chan_t    out_channel,
    input logic                is_high,
    input logic                long_high,
    input logic                long_low,
    input logic                rising_seen,
    input logic                falling_seen
);
    // A stalled result keeps its transaction unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_channel) && $stable(is_high)
            && $stable(long_high) && $stable(long_low) && $stable(rising_seen)
            && $stable(falling_seen))
        else $error("stalled result changed");

    // Back-pressure at the input only arises from a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A cycle spent in reset leaves no result offered and no input stalled.
    assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
        else $error("handshake active after reset");

    // A result only appears after an edge at which the input was free to move.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared while input was stalled");

    // A stalled input transaction is held unchanged by the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(channel) && $stable(level)
            && $stable(now_time) && $stable(clear_flags))
        else $error("stalled input changed");

endmodule

bind debounce_edge_long_hold_detector delhd_checker u_delhd_checker (.*);
